>>> src/fss_pkg.sv
// ----------------------------------------------------------------------------
// Free slot fit search package
// Shared widths, codes and the search token that travels along the cell row.
// ----------------------------------------------------------------------------
package fss_pkg;

  localparam int unsigned SLOT_COUNT_DEF = 64;
  localparam int unsigned SLOT_W         = 6;
  localparam int unsigned SIZE_W         = 8;
  localparam int unsigned POLICY_W       = 3;

  // Policy register codes.
  localparam logic [POLICY_W-1:0] POL_EXACT       = 3'd0;
  localparam logic [POLICY_W-1:0] POL_BEST        = 3'd1;
  localparam logic [POLICY_W-1:0] POL_FIRST       = 3'd2;
  localparam logic [POLICY_W-1:0] POL_EXACT_BEST  = 3'd3;
  localparam logic [POLICY_W-1:0] POL_EXACT_FIRST = 3'd4;

  // Item modes.
  localparam logic MODE_WRITE  = 1'b0;
  localparam logic MODE_LOOKUP = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_SEARCH
  } st_e;

  // Running candidates of one lookup as it passes through the cells.
  typedef struct packed {
    logic [SIZE_W-1:0] req;
    logic              exact_hit;
    logic [SLOT_W-1:0] exact_idx;
    logic [SIZE_W-1:0] exact_size;
    logic              best_hit;
    logic [SLOT_W-1:0] best_idx;
    logic [SIZE_W-1:0] best_size;
    logic              first_hit;
    logic [SLOT_W-1:0] first_idx;
    logic [SIZE_W-1:0] first_size;
  } token_t;

endpackage

>>> src/free_slot_fit_search.sv
// ----------------------------------------------------------------------------
// Free slot fit search
// Slot table searched by exact, best or first fit along a row of cells.
// ----------------------------------------------------------------------------
// A write is registered in its cell and takes effect in the next cycle; a
// lookup result passes through each cell register, the end register and the
// output register. One write per cycle while no lookup is in flight; a lookup
// holds the input off until its result moves into the output register.
// Reset clears all slot valid marks, the policy register and the pipeline.
module free_slot_fit_search import fss_pkg::*; #(
  parameter int unsigned SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [POLICY_W-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                mode_i,
  input  logic [SLOT_W-1:0]   slot_number_i,
  input  logic [SIZE_W-1:0]   slot_size_in_i,
  input  logic                slot_valid_in_i,
  input  logic [SIZE_W-1:0]   request_size_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                found_o,
  output logic [SLOT_W-1:0]   found_slot_o,
  output logic [SIZE_W-1:0]   found_size_o
);

  logic [POLICY_W-1:0] policy_q;
  st_e                 st_q, st_d;
  logic                in_acc, wr_acc, lk_acc;
  logic                end_vld_q;
  token_t              end_q;
  logic                out_vld_q;
  logic                out_found_q;
  logic [SLOT_W-1:0]   out_slot_q;
  logic [SIZE_W-1:0]   out_size_q;
  logic                out_load;
  logic                res_found;
  logic [SLOT_W-1:0]   res_slot;
  logic [SIZE_W-1:0]   res_size;
  logic                chain_vld [SLOT_COUNT+1];
  token_t              chain_tok [SLOT_COUNT+1];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= POL_EXACT;
    end else if (cfg_valid_i) begin
      policy_q <= cfg_data_i;
    end
  end

  assign in_stall_o = (st_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign wr_acc     = in_acc && (mode_i == MODE_WRITE);
  assign lk_acc     = in_acc && (mode_i == MODE_LOOKUP);

  // A fresh token enters the first cell with no candidates yet.
  always_comb begin
    chain_tok[0]     = '0;
    chain_tok[0].req = request_size_i;
  end
  assign chain_vld[0] = lk_acc;

  for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
    // Only cells that a 6-bit slot number can address are ever written.
    localparam bit REACH = (i < (1 << SLOT_W));
    logic we;
    assign we = REACH && wr_acc && (slot_number_i == SLOT_W'(i));

    fss_cell #(
      .INDEX (i)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .wr_en_i    (we),
      .wr_size_i  (slot_size_in_i),
      .wr_valid_i (slot_valid_in_i),
      .tok_vld_i  (chain_vld[i]),
      .tok_i      (chain_tok[i]),
      .tok_vld_o  (chain_vld[i+1]),
      .tok_o      (chain_tok[i+1])
    );
  end

  // The finished token waits here until the output register is free.
  assign out_load = end_vld_q && (!out_vld_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      end_vld_q <= 1'b0;
    end else if (chain_vld[SLOT_COUNT]) begin
      end_vld_q <= 1'b1;
    end else if (out_load) begin
      end_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (chain_vld[SLOT_COUNT]) begin
      end_q <= chain_tok[SLOT_COUNT];
    end
  end

  always_comb begin
    res_found = 1'b0;
    res_slot  = '0;
    res_size  = '0;
    unique case (policy_q)
      POL_EXACT: begin
        res_found = end_q.exact_hit;
        res_slot  = end_q.exact_idx;
        res_size  = end_q.exact_size;
      end
      POL_BEST: begin
        res_found = end_q.best_hit;
        res_slot  = end_q.best_idx;
        res_size  = end_q.best_size;
      end
      POL_FIRST: begin
        res_found = end_q.first_hit;
        res_slot  = end_q.first_idx;
        res_size  = end_q.first_size;
      end
      POL_EXACT_BEST: begin
        if (end_q.exact_hit) begin
          res_found = 1'b1;
          res_slot  = end_q.exact_idx;
          res_size  = end_q.exact_size;
        end else begin
          res_found = end_q.best_hit;
          res_slot  = end_q.best_idx;
          res_size  = end_q.best_size;
        end
      end
      POL_EXACT_FIRST: begin
        if (end_q.exact_hit) begin
          res_found = 1'b1;
          res_slot  = end_q.exact_idx;
          res_size  = end_q.exact_size;
        end else begin
          res_found = end_q.first_hit;
          res_slot  = end_q.first_idx;
          res_size  = end_q.first_size;
        end
      end
      default: begin
        res_found = 1'b0;
      end
    endcase
    if (!res_found) begin
      res_slot = '0;
      res_size = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_found_q <= res_found;
      out_slot_q  <= res_slot;
      out_size_q  <= res_size;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE: begin
        if (lk_acc) begin
          st_d = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (out_load) begin
          st_d = ST_IDLE;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o  = out_vld_q;
  assign found_o      = out_found_q;
  assign found_slot_o = out_slot_q;
  assign found_size_o = out_size_q;

endmodule

>>> src/fss_cell.sv
// ----------------------------------------------------------------------------
// Free slot fit search cell
// Holds one slot and folds it into the search token passing by.
// ----------------------------------------------------------------------------
module fss_cell import fss_pkg::*; #(
  parameter int unsigned INDEX = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_en_i,
  input  logic [SIZE_W-1:0] wr_size_i,
  input  logic              wr_valid_i,
  input  logic              tok_vld_i,
  input  token_t            tok_i,
  output logic              tok_vld_o,
  output token_t            tok_o
);

  localparam logic [SLOT_W-1:0] MY_IDX = SLOT_W'(INDEX);

  logic [SIZE_W-1:0] size_q;
  logic              valid_q;
  logic              tok_vld_q;
  token_t            tok_q, tok_d;
  logic              hit_eq, hit_ge;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      size_q <= wr_size_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= 1'b0;
      tok_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q <= wr_valid_i;
      end
      tok_vld_q <= tok_vld_i;
    end
  end

  assign hit_eq = valid_q && (size_q == tok_i.req);
  assign hit_ge = valid_q && (size_q >= tok_i.req);

  always_comb begin
    tok_d = tok_i;
    if (!tok_i.exact_hit && hit_eq) begin
      tok_d.exact_hit  = 1'b1;
      tok_d.exact_idx  = MY_IDX;
      tok_d.exact_size = size_q;
    end
    if (!tok_i.first_hit && hit_ge) begin
      tok_d.first_hit  = 1'b1;
      tok_d.first_idx  = MY_IDX;
      tok_d.first_size = size_q;
    end
    // Strictly smaller wins, so the lower index is kept on ties.
    if (hit_ge && (!tok_i.best_hit || (size_q < tok_i.best_size))) begin
      tok_d.best_hit  = 1'b1;
      tok_d.best_idx  = MY_IDX;
      tok_d.best_size = size_q;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q <= tok_d;
  end

  assign tok_vld_o = tok_vld_q;
  assign tok_o     = tok_q;

endmodule
